>>> hw/rtl/assert_macros.svh
// Assertion helpers for the RTL; both sample on aclk and are disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMP(lbl, ant, con) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (con)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(lbl, ant, con) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (con)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ant, con)
`define ASSERT_NXT(lbl, ant, con)
`endif

`endif

>>> hw/rtl/ecpsm_pkg.sv
package ecpsm_pkg;

    localparam int FIELD_BITS = 31;
    localparam int CNT_W      = $clog2(FIELD_BITS);
    localparam int NUM_SEL    = 32;

    typedef logic [FIELD_BITS-1:0] word_t;

    localparam word_t PRIME_RST = word_t'(17);
    localparam word_t CA_RST    = word_t'(2);
    localparam word_t ORDER_RST = word_t'(19);

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_PRIME = 2'd0,
        CFG_CURVE_A = 2'd1,
        CFG_ORDER = 2'd2
    } cfg_idx_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ADD,
        OP_SUB,
        OP_MOV,
        OP_MUL,
        OP_RED,
        OP_REDK,
        OP_INVINIT,
        OP_SHK,
        OP_SHE,
        OP_OUT
    } dp_op_t;

    // datapath register selects
    typedef enum logic [4:0] {
        SEL_PX, SEL_PY, SEL_QX, SEL_QY, SEL_RX, SEL_RY,
        SEL_AX, SEL_AY, SEL_BX, SEL_BY, SEL_OX, SEL_OY,
        SEL_LAM, SEL_NUM, SEL_T0, SEL_T1, SEL_ACC, SEL_BASE,
        SEL_CA, SEL_K,
        SEL_IPX, SEL_IPY, SEL_IQX, SEL_IQY, SEL_CAR
    } reg_sel_t;

    typedef struct packed {
        logic     go;
        dp_op_t   op;
        reg_sel_t dst;
        reg_sel_t sa;
        reg_sel_t sb;
        logic     inf;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic eq;
        logic zero;
        logic k_zero;
        logic k_lsb;
        logic e_zero;
        logic e_lsb;
    } dp_status_t;

endpackage

>>> hw/rtl/ecpsm_dp.sv
module ecpsm_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  load,
    input  logic [ecpsm_pkg::FIELD_BITS-1:0]      in_scalar,
    input  logic [ecpsm_pkg::FIELD_BITS-1:0]      in_px,
    input  logic [ecpsm_pkg::FIELD_BITS-1:0]      in_py,
    input  logic [ecpsm_pkg::FIELD_BITS-1:0]      in_qx,
    input  logic [ecpsm_pkg::FIELD_BITS-1:0]      in_qy,
    input  logic                                  cfg_wen,
    input  logic [1:0]                            cfg_index,
    input  logic [ecpsm_pkg::FIELD_BITS-1:0]      cfg_wdata,
    input  ecpsm_pkg::dp_cmd_t                    cmd,
    output ecpsm_pkg::dp_status_t                 status,
    output logic [ecpsm_pkg::FIELD_BITS-1:0]      res_x,
    output logic [ecpsm_pkg::FIELD_BITS-1:0]      res_y,
    output logic                                  res_inf
);

    localparam int FB = ecpsm_pkg::FIELD_BITS;

    // configuration
    ecpsm_pkg::word_t prime_reg, ca_raw_reg, order_reg;

    // working registers
    ecpsm_pkg::word_t px_reg, py_reg, qx_reg, qy_reg, rx_reg, ry_reg;
    ecpsm_pkg::word_t ax_reg, ay_reg, bx_reg, by_reg, ox_reg, oy_reg;
    ecpsm_pkg::word_t lam_reg, num_reg, t0_reg, t1_reg, acc_reg, base_reg;
    ecpsm_pkg::word_t ca_reg, k_reg, e_reg;
    ecpsm_pkg::word_t ipx_reg, ipy_reg, iqx_reg, iqy_reg, isc_reg;
    ecpsm_pkg::word_t out_x_reg, out_y_reg;
    logic             out_inf_reg;

    // serial multiply / reduce unit
    logic                        busy_reg, done_reg, mul_mode_reg;
    logic [ecpsm_pkg::CNT_W-1:0] cnt_reg;
    ecpsm_pkg::word_t            uacc_reg, opa_reg, opb_reg, div_reg;
    ecpsm_pkg::reg_sel_t         wdst_reg;

    ecpsm_pkg::word_t modulus, exp_val, one_val, val_a, val_b;
    ecpsm_pkg::word_t rd_vec [ecpsm_pkg::NUM_SEL];
    ecpsm_pkg::word_t add_res, sub_res, step_res, wr_val;
    logic [FB:0]      sum, dif;
    logic [FB+1:0]    mt;
    logic [FB:0]      rt;
    logic             wr_en, unit_start, unit_end;
    ecpsm_pkg::reg_sel_t wr_sel;

    // effective modulus: a zero prime acts as one
    assign modulus = (prime_reg == '0) ? ecpsm_pkg::word_t'(1) : prime_reg;
    assign exp_val = (prime_reg >= ecpsm_pkg::word_t'(2)) ? prime_reg - ecpsm_pkg::word_t'(2)
                                                          : '0;
    assign one_val = (modulus == ecpsm_pkg::word_t'(1)) ? '0 : ecpsm_pkg::word_t'(1);

    // operand read mux
    always_comb begin
        rd_vec = '{default: '0};
        rd_vec[ecpsm_pkg::SEL_PX]   = px_reg;
        rd_vec[ecpsm_pkg::SEL_PY]   = py_reg;
        rd_vec[ecpsm_pkg::SEL_QX]   = qx_reg;
        rd_vec[ecpsm_pkg::SEL_QY]   = qy_reg;
        rd_vec[ecpsm_pkg::SEL_RX]   = rx_reg;
        rd_vec[ecpsm_pkg::SEL_RY]   = ry_reg;
        rd_vec[ecpsm_pkg::SEL_AX]   = ax_reg;
        rd_vec[ecpsm_pkg::SEL_AY]   = ay_reg;
        rd_vec[ecpsm_pkg::SEL_BX]   = bx_reg;
        rd_vec[ecpsm_pkg::SEL_BY]   = by_reg;
        rd_vec[ecpsm_pkg::SEL_OX]   = ox_reg;
        rd_vec[ecpsm_pkg::SEL_OY]   = oy_reg;
        rd_vec[ecpsm_pkg::SEL_LAM]  = lam_reg;
        rd_vec[ecpsm_pkg::SEL_NUM]  = num_reg;
        rd_vec[ecpsm_pkg::SEL_T0]   = t0_reg;
        rd_vec[ecpsm_pkg::SEL_T1]   = t1_reg;
        rd_vec[ecpsm_pkg::SEL_ACC]  = acc_reg;
        rd_vec[ecpsm_pkg::SEL_BASE] = base_reg;
        rd_vec[ecpsm_pkg::SEL_CA]   = ca_reg;
        rd_vec[ecpsm_pkg::SEL_K]    = k_reg;
        rd_vec[ecpsm_pkg::SEL_IPX]  = ipx_reg;
        rd_vec[ecpsm_pkg::SEL_IPY]  = ipy_reg;
        rd_vec[ecpsm_pkg::SEL_IQX]  = iqx_reg;
        rd_vec[ecpsm_pkg::SEL_IQY]  = iqy_reg;
        rd_vec[ecpsm_pkg::SEL_CAR]  = ca_raw_reg;
    end

    assign val_a = rd_vec[cmd.sa];
    assign val_b = rd_vec[cmd.sb];

    // modular add and subtract of reduced operands
    assign sum     = {1'b0, val_a} + {1'b0, val_b};
    assign add_res = (sum >= {1'b0, modulus}) ? FB'(sum - {1'b0, modulus}) : sum[FB-1:0];
    assign dif     = (val_a >= val_b) ? {1'b0, val_a} - {1'b0, val_b}
                                      : {1'b0, val_a} + {1'b0, modulus} - {1'b0, val_b};
    assign sub_res = dif[FB-1:0];

    // one bit step: multiply is double-and-add mod m, reduce is restoring remainder
    assign mt = {1'b0, uacc_reg, 1'b0} + {2'b00, (opb_reg[FB-1] ? opa_reg : '0)};
    assign rt = {uacc_reg, opb_reg[FB-1]};
    always_comb begin
        if (mul_mode_reg) begin
            if (mt >= {1'b0, div_reg, 1'b0}) begin
                step_res = FB'(mt - {1'b0, div_reg, 1'b0});
            end else if (mt >= {2'b00, div_reg}) begin
                step_res = FB'(mt - {2'b00, div_reg});
            end else begin
                step_res = mt[FB-1:0];
            end
        end else begin
            step_res = (rt >= {1'b0, div_reg}) ? FB'(rt - {1'b0, div_reg}) : rt[FB-1:0];
        end
    end

    assign unit_start = cmd.go && (cmd.op == ecpsm_pkg::OP_MUL || cmd.op == ecpsm_pkg::OP_RED
                        || (cmd.op == ecpsm_pkg::OP_REDK && order_reg != '0));
    assign unit_end   = busy_reg && (cnt_reg == '0);

    // register file write port
    always_comb begin
        wr_en  = 1'b0;
        wr_sel = cmd.dst;
        wr_val = val_a;
        if (unit_end) begin
            wr_en  = 1'b1;
            wr_sel = wdst_reg;
            wr_val = step_res;
        end else if (cmd.go) begin
            case (cmd.op)
                ecpsm_pkg::OP_ADD: begin
                    wr_en  = 1'b1;
                    wr_val = add_res;
                end
                ecpsm_pkg::OP_SUB: begin
                    wr_en  = 1'b1;
                    wr_val = sub_res;
                end
                ecpsm_pkg::OP_MOV: begin
                    wr_en  = 1'b1;
                end
                ecpsm_pkg::OP_INVINIT: begin
                    wr_en  = 1'b1;
                    wr_sel = ecpsm_pkg::SEL_ACC;
                    wr_val = one_val;
                end
                ecpsm_pkg::OP_REDK: begin
                    wr_en  = (order_reg == '0);
                    wr_sel = ecpsm_pkg::SEL_K;
                    wr_val = isc_reg;
                end
                default: begin
                    wr_en  = 1'b0;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prime_reg  <= ecpsm_pkg::PRIME_RST;
            ca_raw_reg <= ecpsm_pkg::CA_RST;
            order_reg  <= ecpsm_pkg::ORDER_RST;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                ecpsm_pkg::CFG_PRIME:   prime_reg  <= cfg_wdata;
                ecpsm_pkg::CFG_CURVE_A: ca_raw_reg <= cfg_wdata;
                ecpsm_pkg::CFG_ORDER:   order_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // unit control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= unit_end || (cmd.go && !unit_start && cmd.op != ecpsm_pkg::OP_OUT);
            if (unit_start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ecpsm_pkg::CNT_W'(FB - 1);
            end else if (busy_reg) begin
                cnt_reg  <= cnt_reg - 1'b1;
                busy_reg <= !unit_end;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (load) begin
            ipx_reg <= in_px;
            ipy_reg <= in_py;
            iqx_reg <= in_qx;
            iqy_reg <= in_qy;
            isc_reg <= in_scalar;
        end
        if (unit_start) begin
            uacc_reg     <= '0;
            mul_mode_reg <= (cmd.op == ecpsm_pkg::OP_MUL);
            opa_reg      <= val_a;
            opb_reg      <= (cmd.op == ecpsm_pkg::OP_MUL) ? val_b
                          : (cmd.op == ecpsm_pkg::OP_REDK) ? isc_reg : val_a;
            div_reg      <= (cmd.op == ecpsm_pkg::OP_REDK) ? order_reg : modulus;
            wdst_reg     <= (cmd.op == ecpsm_pkg::OP_REDK) ? ecpsm_pkg::SEL_K : cmd.dst;
        end else if (busy_reg) begin
            uacc_reg <= step_res;
            opb_reg  <= {opb_reg[FB-2:0], 1'b0};
        end
        if (cmd.go && cmd.op == ecpsm_pkg::OP_INVINIT) begin
            base_reg <= val_a;
            e_reg    <= exp_val;
        end
        if (cmd.go && cmd.op == ecpsm_pkg::OP_SHE) begin
            e_reg <= e_reg >> 1;
        end
        if (cmd.go && cmd.op == ecpsm_pkg::OP_SHK) begin
            k_reg <= k_reg >> 1;
        end
        if (cmd.go && cmd.op == ecpsm_pkg::OP_OUT) begin
            out_x_reg   <= cmd.inf ? '0 : rx_reg;
            out_y_reg   <= cmd.inf ? '0 : ry_reg;
            out_inf_reg <= cmd.inf;
        end
        if (wr_en) begin
            case (wr_sel)
                ecpsm_pkg::SEL_PX:   px_reg   <= wr_val;
                ecpsm_pkg::SEL_PY:   py_reg   <= wr_val;
                ecpsm_pkg::SEL_QX:   qx_reg   <= wr_val;
                ecpsm_pkg::SEL_QY:   qy_reg   <= wr_val;
                ecpsm_pkg::SEL_RX:   rx_reg   <= wr_val;
                ecpsm_pkg::SEL_RY:   ry_reg   <= wr_val;
                ecpsm_pkg::SEL_AX:   ax_reg   <= wr_val;
                ecpsm_pkg::SEL_AY:   ay_reg   <= wr_val;
                ecpsm_pkg::SEL_BX:   bx_reg   <= wr_val;
                ecpsm_pkg::SEL_BY:   by_reg   <= wr_val;
                ecpsm_pkg::SEL_OX:   ox_reg   <= wr_val;
                ecpsm_pkg::SEL_OY:   oy_reg   <= wr_val;
                ecpsm_pkg::SEL_LAM:  lam_reg  <= wr_val;
                ecpsm_pkg::SEL_NUM:  num_reg  <= wr_val;
                ecpsm_pkg::SEL_T0:   t0_reg   <= wr_val;
                ecpsm_pkg::SEL_T1:   t1_reg   <= wr_val;
                ecpsm_pkg::SEL_ACC:  acc_reg  <= wr_val;
                ecpsm_pkg::SEL_BASE: base_reg <= wr_val;
                ecpsm_pkg::SEL_CA:   ca_reg   <= wr_val;
                ecpsm_pkg::SEL_K:    k_reg    <= wr_val;
                default: ;
            endcase
        end
    end

    // status back to the controller
    assign status.busy   = busy_reg;
    assign status.done   = done_reg;
    assign status.eq     = (val_a == val_b);
    assign status.zero   = (val_a == '0);
    assign status.k_zero = (k_reg == '0);
    assign status.k_lsb  = k_reg[0];
    assign status.e_zero = (e_reg == '0);
    assign status.e_lsb  = e_reg[0];

    assign res_x   = out_x_reg;
    assign res_y   = out_y_reg;
    assign res_inf = out_inf_reg;

endmodule

>>> hw/rtl/ecpsm_ctrl.sv
`include "assert_macros.svh"

module ecpsm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_func,
    input  logic                  s_first_inf,
    input  logic                  s_second_inf,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  load,
    output ecpsm_pkg::dp_cmd_t    cmd,
    input  ecpsm_pkg::dp_status_t status
);

    typedef enum logic [5:0] {
        ST_IDLE, ST_RED_CA, ST_RED_PX, ST_RED_PY, ST_RED_QX, ST_RED_QY,
        ST_DISPATCH, ST_RED_K, ST_SC_LOOP, ST_SC_SHK,
        ST_SET_AX, ST_SET_AY, ST_SET_BX, ST_SET_BY, ST_PA_CHECK,
        ST_CP_AX, ST_CP_AY, ST_CP_BX, ST_CP_BY,
        ST_PD_SUM, ST_PD_Z, ST_PD_1, ST_PD_2, ST_PD_3, ST_PD_4, ST_PD_5,
        ST_PD_6, ST_PD_7, ST_PD_8, ST_PD_9,
        ST_PN_1, ST_PN_2, ST_PN_3, ST_PN_4, ST_PN_5, ST_PN_6,
        ST_PY_1, ST_PY_2, ST_PY_3,
        ST_WB_X, ST_WB_Y, ST_WB_DONE,
        ST_INV_INIT, ST_INV_LOOP, ST_INV_MA, ST_INV_SQ, ST_INV_SH, ST_INV_END,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MD_ADD,
        MD_RP,
        MD_PP
    } mode_t;

    state_t state_reg, inv_ret_reg, nxt;
    mode_t  mode_reg;
    logic   wait_reg, m_valid_reg, m_valid_next, func_reg;
    logic   pinf_reg, qinf_reg, rinf_reg, ainf_reg, binf_reg, oinf_reg;
    logic   op_state, out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign load     = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // hold the result beat until taken, raise it when a new one is written
    assign m_valid_next = (m_valid_reg && !m_ready) || (state_reg == ST_FINISH && out_free);

    // command decode per state
    always_comb begin
        op_state = 1'b1;
        nxt      = state_reg;
        cmd.op   = ecpsm_pkg::OP_NOP;
        cmd.dst  = ecpsm_pkg::SEL_T0;
        cmd.sa   = ecpsm_pkg::SEL_T0;
        cmd.sb   = ecpsm_pkg::SEL_T0;
        cmd.inf  = rinf_reg;
        unique case (state_reg)
            ST_RED_CA: begin
                cmd.op = ecpsm_pkg::OP_RED; cmd.dst = ecpsm_pkg::SEL_CA;
                cmd.sa = ecpsm_pkg::SEL_CAR; nxt = ST_RED_PX;
            end
            ST_RED_PX: begin
                cmd.op = ecpsm_pkg::OP_RED; cmd.dst = ecpsm_pkg::SEL_PX;
                cmd.sa = ecpsm_pkg::SEL_IPX; nxt = ST_RED_PY;
            end
            ST_RED_PY: begin
                cmd.op = ecpsm_pkg::OP_RED; cmd.dst = ecpsm_pkg::SEL_PY;
                cmd.sa = ecpsm_pkg::SEL_IPY; nxt = ST_RED_QX;
            end
            ST_RED_QX: begin
                cmd.op = ecpsm_pkg::OP_RED; cmd.dst = ecpsm_pkg::SEL_QX;
                cmd.sa = ecpsm_pkg::SEL_IQX; nxt = ST_RED_QY;
            end
            ST_RED_QY: begin
                cmd.op = ecpsm_pkg::OP_RED; cmd.dst = ecpsm_pkg::SEL_QY;
                cmd.sa = ecpsm_pkg::SEL_IQY; nxt = ST_DISPATCH;
            end
            ST_RED_K: begin
                cmd.op = ecpsm_pkg::OP_REDK; cmd.dst = ecpsm_pkg::SEL_K; nxt = ST_SC_LOOP;
            end
            ST_SC_SHK: begin
                cmd.op = ecpsm_pkg::OP_SHK; nxt = ST_SC_LOOP;
            end
            ST_SET_AX: begin
                cmd.op = ecpsm_pkg::OP_MOV; cmd.dst = ecpsm_pkg::SEL_AX;
                cmd.sa = (mode_reg == MD_RP) ? ecpsm_pkg::SEL_RX : ecpsm_pkg::SEL_PX;
                nxt = ST_SET_AY;
            end
            ST_SET_AY: begin
                cmd.op = ecpsm_pkg::OP_MOV; cmd.dst = ecpsm_pkg::SEL_AY;
                cmd.sa = (mode_reg == MD_RP) ? ecpsm_pkg::SEL_RY : ecpsm_pkg::SEL_PY;
                nxt = ST_SET_BX;
            end
            ST_SET_BX: begin
                cmd.op = ecpsm_pkg::OP_MOV; cmd.dst = ecpsm_pkg::SEL_BX;
                cmd.sa = (mode_reg == MD_ADD) ? ecpsm_pkg::SEL_QX : ecpsm_pkg::SEL_PX;
                nxt = ST_SET_BY;
            end
            ST_SET_BY: begin
                cmd.op = ecpsm_pkg::OP_MOV; cmd.dst = ecpsm_pkg::SEL_BY;
                cmd.sa = (mode_reg == MD_ADD) ? ecpsm_pkg::SEL_QY : ecpsm_pkg::SEL_PY;
                nxt = ST_PA_CHECK;
            end
            ST_CP_AX: begin
                cmd.op = ecpsm_pkg::OP_MOV; cmd.dst = ecpsm_pkg::SEL_OX;
                cmd.sa = ecpsm_pkg::SEL_AX; nxt = ST_CP_AY;
            end
            ST_CP_AY: begin
                cmd.op = ecpsm_pkg::OP_MOV; cmd.dst = ecpsm_pkg::SEL_OY;
                cmd.sa = ecpsm_pkg::SEL_AY; nxt = ST_WB_X;
            end
            ST_CP_BX: begin
                cmd.op = ecpsm_pkg::OP_MOV; cmd.dst = ecpsm_pkg::SEL_OX;
                cmd.sa = ecpsm_pkg::SEL_BX; nxt = ST_CP_BY;
            end
            ST_CP_BY: begin
                cmd.op = ecpsm_pkg::OP_MOV; cmd.dst = ecpsm_pkg::SEL_OY;
                cmd.sa = ecpsm_pkg::SEL_BY; nxt = ST_WB_X;
            end
            // doubling branch
            ST_PD_SUM: begin
                cmd.op = ecpsm_pkg::OP_ADD; cmd.dst = ecpsm_pkg::SEL_T0;
                cmd.sa = ecpsm_pkg::SEL_AY; cmd.sb = ecpsm_pkg::SEL_BY; nxt = ST_PD_Z;
            end
            ST_PD_1: begin
                cmd.op = ecpsm_pkg::OP_MUL; cmd.dst = ecpsm_pkg::SEL_T0;
                cmd.sa = ecpsm_pkg::SEL_AX; cmd.sb = ecpsm_pkg::SEL_AX; nxt = ST_PD_2;
            end
            ST_PD_2: begin
                cmd.op = ecpsm_pkg::OP_ADD; cmd.dst = ecpsm_pkg::SEL_T1;
                cmd.sa = ecpsm_pkg::SEL_T0; cmd.sb = ecpsm_pkg::SEL_T0; nxt = ST_PD_3;
            end
            ST_PD_3: begin
                cmd.op = ecpsm_pkg::OP_ADD; cmd.dst = ecpsm_pkg::SEL_T0;
                cmd.sa = ecpsm_pkg::SEL_T1; cmd.sb = ecpsm_pkg::SEL_T0; nxt = ST_PD_4;
            end
            ST_PD_4: begin
                cmd.op = ecpsm_pkg::OP_ADD; cmd.dst = ecpsm_pkg::SEL_NUM;
                cmd.sa = ecpsm_pkg::SEL_T0; cmd.sb = ecpsm_pkg::SEL_CA; nxt = ST_PD_5;
            end
            ST_PD_5: begin
                cmd.op = ecpsm_pkg::OP_ADD; cmd.dst = ecpsm_pkg::SEL_T1;
                cmd.sa = ecpsm_pkg::SEL_AY; cmd.sb = ecpsm_pkg::SEL_AY; nxt = ST_INV_INIT;
            end
            ST_PD_6: begin
                cmd.op = ecpsm_pkg::OP_MUL; cmd.dst = ecpsm_pkg::SEL_LAM;
                cmd.sa = ecpsm_pkg::SEL_NUM; cmd.sb = ecpsm_pkg::SEL_T1; nxt = ST_PD_7;
            end
            ST_PD_7: begin
                cmd.op = ecpsm_pkg::OP_MUL; cmd.dst = ecpsm_pkg::SEL_T0;
                cmd.sa = ecpsm_pkg::SEL_LAM; cmd.sb = ecpsm_pkg::SEL_LAM; nxt = ST_PD_8;
            end
            ST_PD_8: begin
                cmd.op = ecpsm_pkg::OP_ADD; cmd.dst = ecpsm_pkg::SEL_T1;
                cmd.sa = ecpsm_pkg::SEL_AX; cmd.sb = ecpsm_pkg::SEL_AX; nxt = ST_PD_9;
            end
            ST_PD_9: begin
                cmd.op = ecpsm_pkg::OP_SUB; cmd.dst = ecpsm_pkg::SEL_OX;
                cmd.sa = ecpsm_pkg::SEL_T0; cmd.sb = ecpsm_pkg::SEL_T1; nxt = ST_PY_1;
            end
            // distinct-x branch
            ST_PN_1: begin
                cmd.op = ecpsm_pkg::OP_SUB; cmd.dst = ecpsm_pkg::SEL_NUM;
                cmd.sa = ecpsm_pkg::SEL_BY; cmd.sb = ecpsm_pkg::SEL_AY; nxt = ST_PN_2;
            end
            ST_PN_2: begin
                cmd.op = ecpsm_pkg::OP_SUB; cmd.dst = ecpsm_pkg::SEL_T1;
                cmd.sa = ecpsm_pkg::SEL_BX; cmd.sb = ecpsm_pkg::SEL_AX; nxt = ST_INV_INIT;
            end
            ST_PN_3: begin
                cmd.op = ecpsm_pkg::OP_MUL; cmd.dst = ecpsm_pkg::SEL_LAM;
                cmd.sa = ecpsm_pkg::SEL_NUM; cmd.sb = ecpsm_pkg::SEL_T1; nxt = ST_PN_4;
            end
            ST_PN_4: begin
                cmd.op = ecpsm_pkg::OP_MUL; cmd.dst = ecpsm_pkg::SEL_T0;
                cmd.sa = ecpsm_pkg::SEL_LAM; cmd.sb = ecpsm_pkg::SEL_LAM; nxt = ST_PN_5;
            end
            ST_PN_5: begin
                cmd.op = ecpsm_pkg::OP_SUB; cmd.dst = ecpsm_pkg::SEL_T0;
                cmd.sa = ecpsm_pkg::SEL_T0; cmd.sb = ecpsm_pkg::SEL_AX; nxt = ST_PN_6;
            end
            ST_PN_6: begin
                cmd.op = ecpsm_pkg::OP_SUB; cmd.dst = ecpsm_pkg::SEL_OX;
                cmd.sa = ecpsm_pkg::SEL_T0; cmd.sb = ecpsm_pkg::SEL_BX; nxt = ST_PY_1;
            end
            // common y
            ST_PY_1: begin
                cmd.op = ecpsm_pkg::OP_SUB; cmd.dst = ecpsm_pkg::SEL_T0;
                cmd.sa = ecpsm_pkg::SEL_AX; cmd.sb = ecpsm_pkg::SEL_OX; nxt = ST_PY_2;
            end
            ST_PY_2: begin
                cmd.op = ecpsm_pkg::OP_MUL; cmd.dst = ecpsm_pkg::SEL_T0;
                cmd.sa = ecpsm_pkg::SEL_LAM; cmd.sb = ecpsm_pkg::SEL_T0; nxt = ST_PY_3;
            end
            ST_PY_3: begin
                cmd.op = ecpsm_pkg::OP_SUB; cmd.dst = ecpsm_pkg::SEL_OY;
                cmd.sa = ecpsm_pkg::SEL_T0; cmd.sb = ecpsm_pkg::SEL_AY; nxt = ST_WB_X;
            end
            // write the sum back to R or P
            ST_WB_X: begin
                cmd.op  = ecpsm_pkg::OP_MOV; cmd.sa = ecpsm_pkg::SEL_OX;
                cmd.dst = (mode_reg == MD_PP) ? ecpsm_pkg::SEL_PX : ecpsm_pkg::SEL_RX;
                nxt = ST_WB_Y;
            end
            ST_WB_Y: begin
                cmd.op  = ecpsm_pkg::OP_MOV; cmd.sa = ecpsm_pkg::SEL_OY;
                cmd.dst = (mode_reg == MD_PP) ? ecpsm_pkg::SEL_PY : ecpsm_pkg::SEL_RY;
                nxt = ST_WB_DONE;
            end
            // Fermat inversion of T1
            ST_INV_INIT: begin
                cmd.op = ecpsm_pkg::OP_INVINIT; cmd.sa = ecpsm_pkg::SEL_T1; nxt = ST_INV_LOOP;
            end
            ST_INV_MA: begin
                cmd.op = ecpsm_pkg::OP_MUL; cmd.dst = ecpsm_pkg::SEL_ACC;
                cmd.sa = ecpsm_pkg::SEL_ACC; cmd.sb = ecpsm_pkg::SEL_BASE; nxt = ST_INV_SQ;
            end
            ST_INV_SQ: begin
                cmd.op = ecpsm_pkg::OP_MUL; cmd.dst = ecpsm_pkg::SEL_BASE;
                cmd.sa = ecpsm_pkg::SEL_BASE; cmd.sb = ecpsm_pkg::SEL_BASE; nxt = ST_INV_SH;
            end
            ST_INV_SH: begin
                cmd.op = ecpsm_pkg::OP_SHE; nxt = ST_INV_LOOP;
            end
            ST_INV_END: begin
                cmd.op = ecpsm_pkg::OP_MOV; cmd.dst = ecpsm_pkg::SEL_T1;
                cmd.sa = ecpsm_pkg::SEL_ACC; nxt = inv_ret_reg;
            end
            ST_PA_CHECK: begin
                op_state = 1'b0;
                cmd.sa = ecpsm_pkg::SEL_AX; cmd.sb = ecpsm_pkg::SEL_BX;
            end
            ST_FINISH: begin
                op_state = 1'b0;
                cmd.op = ecpsm_pkg::OP_OUT;
            end
            default: begin
                op_state = 1'b0;
            end
        endcase
        cmd.go = (op_state && !wait_reg) || (state_reg == ST_FINISH && out_free);
    end

    // sequencer, flags and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            inv_ret_reg <= ST_PN_3;
            mode_reg    <= MD_ADD;
            wait_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            func_reg    <= 1'b0;
            pinf_reg    <= 1'b0;
            qinf_reg    <= 1'b0;
            rinf_reg    <= 1'b0;
            ainf_reg    <= 1'b0;
            binf_reg    <= 1'b0;
            oinf_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (op_state) begin
                if (!wait_reg) begin
                    wait_reg <= 1'b1;
                end else if (status.done) begin
                    wait_reg  <= 1'b0;
                    state_reg <= nxt;
                end
            end else begin
                unique case (state_reg)
                    ST_IDLE: begin
                        if (s_valid) begin
                            func_reg  <= s_func;
                            pinf_reg  <= s_first_inf;
                            qinf_reg  <= s_second_inf;
                            state_reg <= ST_RED_CA;
                        end
                    end
                    ST_DISPATCH: begin
                        if (!func_reg) begin
                            mode_reg  <= MD_ADD;
                            ainf_reg  <= pinf_reg;
                            binf_reg  <= qinf_reg;
                            state_reg <= ST_SET_AX;
                        end else begin
                            rinf_reg  <= 1'b1;
                            state_reg <= ST_RED_K;
                        end
                    end
                    ST_SC_LOOP: begin
                        if (status.k_zero) begin
                            state_reg <= ST_FINISH;
                        end else if (status.k_lsb) begin
                            mode_reg  <= MD_RP;
                            ainf_reg  <= rinf_reg;
                            binf_reg  <= pinf_reg;
                            state_reg <= ST_SET_AX;
                        end else begin
                            mode_reg  <= MD_PP;
                            ainf_reg  <= pinf_reg;
                            binf_reg  <= pinf_reg;
                            state_reg <= ST_SET_AX;
                        end
                    end
                    ST_PA_CHECK: begin
                        if (ainf_reg) begin
                            oinf_reg  <= binf_reg;
                            state_reg <= ST_CP_BX;
                        end else if (binf_reg) begin
                            oinf_reg  <= 1'b0;
                            state_reg <= ST_CP_AX;
                        end else if (status.eq) begin
                            oinf_reg    <= 1'b0;
                            inv_ret_reg <= ST_PD_6;
                            state_reg   <= ST_PD_SUM;
                        end else begin
                            oinf_reg    <= 1'b0;
                            inv_ret_reg <= ST_PN_3;
                            state_reg   <= ST_PN_1;
                        end
                    end
                    ST_PD_Z: begin
                        // opposite points sum to infinity
                        if (status.zero) begin
                            oinf_reg  <= 1'b1;
                            state_reg <= ST_WB_X;
                        end else begin
                            state_reg <= ST_PD_1;
                        end
                    end
                    ST_WB_DONE: begin
                        unique case (mode_reg)
                            MD_ADD: begin
                                rinf_reg  <= oinf_reg;
                                state_reg <= ST_FINISH;
                            end
                            MD_RP: begin
                                rinf_reg  <= oinf_reg;
                                mode_reg  <= MD_PP;
                                ainf_reg  <= pinf_reg;
                                binf_reg  <= pinf_reg;
                                state_reg <= ST_SET_AX;
                            end
                            default: begin
                                pinf_reg  <= oinf_reg;
                                state_reg <= ST_SC_SHK;
                            end
                        endcase
                    end
                    ST_INV_LOOP: begin
                        if (status.e_zero) begin
                            state_reg <= ST_INV_END;
                        end else if (status.e_lsb) begin
                            state_reg <= ST_INV_MA;
                        end else begin
                            state_reg <= ST_INV_SQ;
                        end
                    end
                    ST_FINISH: begin
                        if (out_free) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    default: begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    `ASSERT_IMP(a_go_not_busy, cmd.go, !status.busy)
    `ASSERT_IMP(a_done_when_waiting, status.done, wait_reg)
    `ASSERT_IMP(a_wait_in_op_state, wait_reg, op_state)
    `ASSERT_NXT(a_one_item_at_a_time, s_valid && s_ready, !s_ready)

endmodule

>>> hw/rtl/ec_point_add_and_scalar_multiply.sv
// Elliptic-curve point addition and scalar multiplication over GF(p),
// affine coordinates with an infinity flag.
// Input channel (s_*): one beat carries the operation, scalar and points
// P and Q; s_func low adds P+Q, high computes scalar*P (scalar reduced by
// the group order if nonzero, LSB-first double-and-add). Result channel
// (m_*): one beat per input with x, y and the infinity flag (x = y = 0 at
// infinity). Configuration (cfg_*): prime, curve a and group order,
// written by index; the user must see that they are written only while
// the block is idle, as the block does not enforce it. Reset loads 17, 2
// and 19. Every field multiply and input reduction runs one bit per cycle
// on a single shared unit. A point addition costs roughly 2 * log2(p)
// multiplies for the Fermat inverse plus three more, or four more for
// a doubling; a scalar multiply costs up to 2 * log2(n) point operations.
// One item is in flight at a time. A finished result sits in the output
// register while the next item is accepted and processed; a stalled
// receiver only holds the block when the following result is ready to be
// written. Reset drops any item in flight.
module ec_point_add_and_scalar_multiply (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_func,
    input  logic [ecpsm_pkg::FIELD_BITS-1:0] s_scalar,
    input  logic [ecpsm_pkg::FIELD_BITS-1:0] s_first_x,
    input  logic [ecpsm_pkg::FIELD_BITS-1:0] s_first_y,
    input  logic                             s_first_inf,
    input  logic [ecpsm_pkg::FIELD_BITS-1:0] s_second_x,
    input  logic [ecpsm_pkg::FIELD_BITS-1:0] s_second_y,
    input  logic                             s_second_inf,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ecpsm_pkg::FIELD_BITS-1:0] m_result_x,
    output logic [ecpsm_pkg::FIELD_BITS-1:0] m_result_y,
    output logic                             m_result_inf,
    input  logic                             cfg_wen,
    input  logic [1:0]                       cfg_index,
    input  logic [ecpsm_pkg::FIELD_BITS-1:0] cfg_wdata
);

    ecpsm_pkg::dp_cmd_t    cmd;
    ecpsm_pkg::dp_status_t status;
    logic                  load;

    // sequencer
    ecpsm_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_first_inf  (s_first_inf),
        .s_second_inf (s_second_inf),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .load         (load),
        .cmd          (cmd),
        .status       (status)
    );

    // field arithmetic
    ecpsm_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .in_scalar (s_scalar),
        .in_px     (s_first_x),
        .in_py     (s_first_y),
        .in_qx     (s_second_x),
        .in_qy     (s_second_y),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .res_x     (m_result_x),
        .res_y     (m_result_y),
        .res_inf   (m_result_inf)
    );

endmodule

>>> tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned u64_t;

    typedef struct {
        u64_t x;
        u64_t y;
        bit   inf;
    } point_t;

    typedef struct {
        bit               func;
        ecpsm_pkg::word_t scalar;
        ecpsm_pkg::word_t px;
        ecpsm_pkg::word_t py;
        bit               pinf;
        ecpsm_pkg::word_t qx;
        ecpsm_pkg::word_t qy;
        bit               qinf;
    } ec_req_t;

    typedef struct {
        ecpsm_pkg::word_t x;
        ecpsm_pkg::word_t y;
        bit               inf;
    } ec_res_t;

    localparam bit               FN_ADD = 1'b0;
    localparam bit               FN_MUL = 1'b1;
    localparam ecpsm_pkg::word_t WMAX   =
        ecpsm_pkg::word_t'((64'd1 << ecpsm_pkg::FIELD_BITS) - 1);

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_func;
    ecpsm_pkg::word_t    s_scalar;
    ecpsm_pkg::word_t    s_first_x;
    ecpsm_pkg::word_t    s_first_y;
    logic                s_first_inf;
    ecpsm_pkg::word_t    s_second_x;
    ecpsm_pkg::word_t    s_second_y;
    logic                s_second_inf;
    logic                m_valid;
    logic                m_ready;
    ecpsm_pkg::word_t    m_result_x;
    ecpsm_pkg::word_t    m_result_y;
    logic                m_result_inf;
    logic                cfg_wen;
    ecpsm_pkg::cfg_idx_t cfg_index;
    ecpsm_pkg::word_t    cfg_wdata;

    // configuration mirror
    u64_t prime_q;
    u64_t curve_a_q;
    u64_t order_q;

    ec_res_t pending_results[$];
    int      errors;
    bit      no_idle;
    int      hold_ready_cycles;

    ec_point_add_and_scalar_multiply dut (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // ---------------- predictor ----------------
    function automatic u64_t fmul(u64_t u, u64_t v, u64_t m);
        return (u * v) % m;
    endfunction

    function automatic u64_t fadd(u64_t u, u64_t v, u64_t m);
        return (u + v) % m;
    endfunction

    function automatic u64_t fsub(u64_t u, u64_t v, u64_t m);
        return (u + m - v) % m;
    endfunction

    // Fermat inverse d^(m-2); exponent clamps to zero for tiny moduli
    function automatic u64_t finv(u64_t d, u64_t m);
        u64_t e;
        u64_t acc;
        u64_t b;
        e   = (m >= 2) ? m - 2 : 0;
        acc = 1 % m;
        b   = d % m;
        while (e > 0) begin
            if (e[0]) acc = fmul(acc, b, m);
            b = fmul(b, b, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic point_t point_at_inf();
        point_t r;
        r.x   = 0;
        r.y   = 0;
        r.inf = 1'b1;
        return r;
    endfunction

    function automatic point_t point_sum(point_t s, point_t t, u64_t m, u64_t ca);
        u64_t   lam;
        u64_t   rx;
        point_t r;
        if (s.inf) return t;
        if (t.inf) return s;
        if (s.x == t.x) begin
            if (fadd(s.y, t.y, m) == 0) return point_at_inf();
            lam = fmul(fadd(fmul(3, fmul(s.x, s.x, m), m), ca, m),
                       finv(fmul(2, s.y, m), m), m);
            rx  = fsub(fmul(lam, lam, m), fmul(2, s.x, m), m);
        end else begin
            lam = fmul(fsub(t.y, s.y, m), finv(fsub(t.x, s.x, m), m), m);
            rx  = fsub(fsub(fmul(lam, lam, m), s.x, m), t.x, m);
        end
        r.x   = rx;
        r.y   = fsub(fmul(lam, fsub(s.x, rx, m), m), s.y, m);
        r.inf = 1'b0;
        return r;
    endfunction

    function automatic point_t load_point(ecpsm_pkg::word_t x, ecpsm_pkg::word_t y, bit f,
                                          u64_t m);
        point_t r;
        if (f) return point_at_inf();
        r.x   = u64_t'(x) % m;
        r.y   = u64_t'(y) % m;
        r.inf = 1'b0;
        return r;
    endfunction

    function automatic ec_res_t ec_predict(ec_req_t rq);
        u64_t    m;
        u64_t    ca;
        u64_t    k;
        point_t  p;
        point_t  r;
        ec_res_t o;
        m  = (prime_q == 0) ? 1 : prime_q;
        ca = curve_a_q % m;
        p  = load_point(rq.px, rq.py, rq.pinf, m);
        if (rq.func == FN_ADD) begin
            r = point_sum(p, load_point(rq.qx, rq.qy, rq.qinf, m), m, ca);
        end else begin
            k = u64_t'(rq.scalar);
            if (order_q != 0) k = k % order_q;
            r = point_at_inf();
            while (k > 0) begin
                if (k[0]) r = point_sum(r, p, m, ca);
                p = point_sum(p, p, m, ca);
                k = k >> 1;
            end
        end
        o.inf = r.inf;
        o.x   = r.inf ? '0 : ecpsm_pkg::word_t'(r.x);
        o.y   = r.inf ? '0 : ecpsm_pkg::word_t'(r.y);
        return o;
    endfunction

    // ---------------- driving helpers ----------------
    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 120);
    endfunction

    // send one beat; valid stays high into the next call when its gap is zero
    task automatic send_item(ec_req_t rq);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        pending_results.push_back(ec_predict(rq));
        s_valid      <= 1'b1;
        s_func       <= rq.func;
        s_scalar     <= rq.scalar;
        s_first_x    <= rq.px;
        s_first_y    <= rq.py;
        s_first_inf  <= rq.pinf;
        s_second_x   <= rq.qx;
        s_second_y   <= rq.qy;
        s_second_inf <= rq.qinf;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait for every outstanding result, then let the block settle
    task automatic drain();
        stop_sending();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_config(u64_t p, u64_t a, u64_t n);
        cfg_wen   <= 1'b1;
        cfg_index <= ecpsm_pkg::CFG_PRIME;
        cfg_wdata <= ecpsm_pkg::word_t'(p);
        @(posedge aclk);
        cfg_index <= ecpsm_pkg::CFG_CURVE_A;
        cfg_wdata <= ecpsm_pkg::word_t'(a);
        @(posedge aclk);
        cfg_index <= ecpsm_pkg::CFG_ORDER;
        cfg_wdata <= ecpsm_pkg::word_t'(n);
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        prime_q   = p;
        curve_a_q = a;
        order_q   = n;
        @(posedge aclk);
    endtask

    function automatic ec_req_t add_req(u64_t px, u64_t py, bit pi, u64_t qx, u64_t qy,
                                        bit qi);
        ec_req_t rq;
        rq.func   = FN_ADD;
        rq.scalar = ecpsm_pkg::word_t'($urandom());
        rq.px     = ecpsm_pkg::word_t'(px);
        rq.py     = ecpsm_pkg::word_t'(py);
        rq.pinf   = pi;
        rq.qx     = ecpsm_pkg::word_t'(qx);
        rq.qy     = ecpsm_pkg::word_t'(qy);
        rq.qinf   = qi;
        return rq;
    endfunction

    function automatic ec_req_t mul_req(u64_t k, u64_t px, u64_t py, bit pi);
        ec_req_t rq;
        rq        = add_req(px, py, pi, $urandom(), $urandom(), $urandom_range(0, 1));
        rq.func   = FN_MUL;
        rq.scalar = ecpsm_pkg::word_t'(k);
        return rq;
    endfunction

    // random coordinate: mostly reduced, sometimes any 31-bit value
    function automatic u64_t rand_coord();
        if ($urandom_range(0, 3) == 0 || prime_q < 2) begin
            return u64_t'(ecpsm_pkg::word_t'($urandom()));
        end
        return $urandom_range(0, int'(prime_q - 1));
    endfunction

    function automatic ec_req_t rand_req();
        ec_req_t rq;
        u64_t    m;
        u64_t    x;
        u64_t    y;
        int      kind;
        m    = (prime_q == 0) ? 1 : prime_q;
        x    = rand_coord();
        y    = rand_coord();
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            rq = mul_req($urandom_range(0, 600), x, y, $urandom_range(0, 15) == 0);
        end else if (kind == 4) begin
            rq = mul_req(u64_t'(ecpsm_pkg::word_t'($urandom())), x, y, 1'b0);
        end else if (kind == 5) begin
            rq = add_req(x, y, 1'b0, x, y, 1'b0);
        end else if (kind == 6) begin
            rq = add_req(x, y, 1'b0, x, (m - (y % m)) % m, 1'b0);
        end else if (kind == 7) begin
            rq = add_req(x, y, 1'b0, x, rand_coord(), 1'b0);
        end else begin
            rq = add_req(x, y, $urandom_range(0, 9) == 0, rand_coord(), rand_coord(),
                         $urandom_range(0, 9) == 0);
        end
        return rq;
    endfunction

    // ---------------- result side ----------------
    // receiver: random stalls, with an occasional long hold-off on request
    initial begin
        int run;
        m_ready <= 1'b0;
        forever begin
            if (hold_ready_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (hold_ready_cycles) @(posedge aclk);
                hold_ready_cycles = 0;
            end else if (no_idle || $urandom_range(0, 9) < 6) begin
                m_ready <= 1'b1;
                run = $urandom_range(1, 40);
                repeat (run) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                  : $urandom_range(1, 3);
                repeat (run) @(posedge aclk);
            end
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        ec_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d inf=%0d", $time,
                         m_result_x, m_result_y, m_result_inf);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_result_x !== want.x) begin
                    $display("%0t: result_x expected %0d actual %0d", $time, want.x,
                             m_result_x);
                    errors++;
                end
                if (m_result_y !== want.y) begin
                    $display("%0t: result_y expected %0d actual %0d", $time, want.y,
                             m_result_y);
                    errors++;
                end
                if (m_result_inf !== want.inf) begin
                    $display("%0t: result_inf expected %0d actual %0d", $time, want.inf,
                             m_result_inf);
                    errors++;
                end
            end
        end
    end

    // ---------------- tests ----------------
    // reset values: identity, inverse, doubling and scalar corner cases
    task automatic test_reset_config();
        send_item(add_req(5, 1, 1'b0, 0, 0, 1'b1));
        send_item(add_req(0, 0, 1'b1, 6, 3, 1'b0));
        send_item(add_req(0, 0, 1'b1, 0, 0, 1'b1));
        send_item(add_req(5, 1, 1'b0, 5, 16, 1'b0));
        send_item(add_req(5, 1, 1'b0, 5, 1, 1'b0));
        send_item(add_req(5, 1, 1'b0, 5, 7, 1'b0));
        send_item(add_req(5, 1, 1'b0, 6, 3, 1'b0));
        send_item(add_req(4, 0, 1'b0, 4, 0, 1'b0));
        send_item(add_req(WMAX, WMAX - 1, 1'b0, 22, 18, 1'b0));
        send_item(mul_req(0, 5, 1, 1'b0));
        send_item(mul_req(19, 5, 1, 1'b0));
        send_item(mul_req(1, 5, 1, 1'b0));
        send_item(mul_req(7, 5, 1, 1'b0));
        send_item(mul_req(WMAX, 5, 1, 1'b0));
        send_item(mul_req(3, 5, 1, 1'b1));
        drain();
    endtask

    // degenerate moduli, unreduced curve_a, zero order and full width
    task automatic test_config_extremes();
        set_config(0, WMAX, 0);
        send_item(add_req(3, 4, 1'b0, 5, 6, 1'b0));
        send_item(mul_req(5, 3, 4, 1'b0));
        drain();
        set_config(1, 0, 2);
        send_item(add_req(3, 4, 1'b0, 3, 4, 1'b0));
        send_item(mul_req(3, 1, 1, 1'b0));
        drain();
        set_config(2, 1, 0);
        send_item(add_req(1, 1, 1'b0, 1, 1, 1'b0));
        send_item(add_req(0, 1, 1'b0, 1, 0, 1'b0));
        send_item(mul_req(WMAX, 1, 1, 1'b0));
        drain();
        set_config(97, 1000, 5);
        send_item(add_req(3, 6, 1'b0, 3, 6, 1'b0));
        send_item(mul_req(13, 3, 6, 1'b0));
        drain();
        set_config(WMAX, WMAX - 1, WMAX);
        send_item(add_req(WMAX - 1, 12345, 1'b0, 7, WMAX - 1, 1'b0));
        send_item(add_req(WMAX - 1, 12345, 1'b0, WMAX - 1, 12345, 1'b0));
        send_item(mul_req(WMAX - 1, 2, 3, 1'b0));
        drain();
    endtask

    // random items under a series of small configurations
    task automatic test_random_items();
        u64_t primes[6] = '{5, 17, 97, 251, 8191, 65521};
        u64_t p;
        for (int ph = 0; ph < 6; ph++) begin
            p = primes[$urandom_range(0, 5)];
            if (ph == 0) p = 5;
            set_config(p, $urandom_range(0, int'(p - 1)),
                       (ph == 1) ? 2 : $urandom_range(2, 300));
            no_idle = (ph == 3);
            repeat (12) send_item(rand_req());
            drain();
        end
        no_idle = 1'b0;
    endtask

    // hold the result side long enough that the input stalls
    task automatic test_output_stall();
        set_config(17, 2, 19);
        hold_ready_cycles = 40000;
        repeat (8) send_item(rand_req());
        drain();
    endtask

    // pause the sender until everything is back, then resume
    task automatic test_sender_pause();
        repeat (3) send_item(rand_req());
        drain();
        repeat (3) send_item(rand_req());
        drain();
    endtask

    initial begin
        errors            = 0;
        no_idle           = 1'b0;
        hold_ready_cycles = 0;
        prime_q           = 17;
        curve_a_q         = 2;
        order_q           = 19;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_func       <= FN_ADD;
        s_scalar     <= '0;
        s_first_x    <= '0;
        s_first_y    <= '0;
        s_first_inf  <= 1'b0;
        s_second_x   <= '0;
        s_second_y   <= '0;
        s_second_inf <= 1'b0;
        cfg_wen      <= 1'b0;
        cfg_index    <= ecpsm_pkg::CFG_PRIME;
        cfg_wdata    <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_config();
        test_config_extremes();
        test_random_items();
        test_output_stall();
        test_sender_pause();

        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(200_000_000);
        $display("tb NOT OK");
        $finish;
    end

endmodule

>>> ec_point_add_and_scalar_multiply.f
+incdir+hw/rtl
hw/rtl/ecpsm_pkg.sv
hw/rtl/ecpsm_dp.sv
hw/rtl/ecpsm_ctrl.sv
hw/rtl/ec_point_add_and_scalar_multiply.sv
tb/sv/tb.sv
